// ----- rtl/disjoint_interval_tracker_assert.svh -----
// Assertion macros used by the checker file.
`ifndef DISJOINT_INTERVAL_TRACKER_ASSERT_SVH
`define DISJOINT_INTERVAL_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and quiet during reset.
`define DIT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("interval tracker port check failed");

// Next-cycle implication, sampled on i_clk and quiet during reset.
`define DIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("interval tracker port check failed");

`endif

// ----- rtl/dit_pkg.sv -----
package dit_pkg;

    // Defaults for the top-level parameters.
    localparam int DefMaxIntervals = 32;
    localparam int DefValueWidth   = 16;

    // Fixed port field widths.
    localparam int FieldW    = 16;
    localparam int CountOutW = 6;
    localparam int OutDataW  = 48;

    // Add status codes.
    typedef enum logic [2:0] {
        ST_PRESENT = 3'd0,
        ST_NEW     = 3'd1,
        ST_EXTEND  = 3'd2,
        ST_MERGE   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic cmp;
        logic upd;
        logic rotate;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic list_last;
    } t_dp_stat;

endpackage

// ----- rtl/disjoint_interval_tracker.sv -----
// Disjoint interval tracker.
// Keeps a sorted table of disjoint closed intervals of values.
// Input channel s_axis: tuser is the mode (0 add, 1 list), tdata the value.
// Output channel m_axis: tuser is the result kind, tlast marks the final
// result of an item, tdata carries status, bounds, empty flag and count.
// An add raises its status result once the compare state has compared the
// value with every entry in parallel and the update state has applied the
// insert, extend or merge shift across the table of entries.
// A list gives its first interval the cycle after its input transaction and
// then one interval per cycle while m_axis_tready is high; the table rotates
// by one entry per delivered interval and is back in order after the last.
// One item is worked on at a time; s_axis_tready is high only while idle,
// so no new item is taken until the last result of the one before is taken.
// Reset empties the table at once. A stalled receiver holds the result,
// and the block waits with it.
module disjoint_interval_tracker
    import dit_pkg::*;
#(
    parameter int MaxIntervals = DefMaxIntervals,
    parameter int ValueWidth   = DefValueWidth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [FieldW-1:0]   s_axis_tdata,   // value
    input  logic                s_axis_tuser,   // mode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // status[2:0], interval_low[18:3], interval_high[34:19],
    // table_empty[35], interval_count[41:36], zero fill[47:42]
    output logic [OutDataW-1:0] m_axis_tdata,
    output logic                m_axis_tuser,   // result_kind
    output logic                m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    dit_datapath #(
        .MaxIntervals (MaxIntervals),
        .ValueWidth   (ValueWidth)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_mode  (s_axis_tuser),
        .i_value (s_axis_tdata),
        .o_stat  (stat),
        .o_kind  (m_axis_tuser),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ----- rtl/dit_ctrl.sv -----
module dit_ctrl
    import dit_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_mode,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CMP     = 5'b00010,
        S_UPD     = 5'b00100,
        S_ADD_OUT = 5'b01000,
        S_LIST    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next-state and command decode.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_in_mode ? S_LIST : S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_ADD_OUT;
            end
            S_ADD_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                o_out_valid  = 1'b1;
                // Each delivered interval rotates the table by one entry.
                o_cmd.rotate = i_out_ready && !i_stat.count_zero;
                if (i_out_ready && (i_stat.count_zero || i_stat.list_last)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/dit_datapath.sv -----
module dit_datapath
    import dit_pkg::*;
#(
    parameter int MaxIntervals = DefMaxIntervals,
    parameter int ValueWidth   = DefValueWidth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_mode,
    input  logic [FieldW-1:0]    i_value,
    output t_dp_stat             o_stat,
    output logic                 o_kind,
    output logic [OutDataW-1:0]  o_data,
    output logic                 o_last
);

    localparam int CW = $clog2(MaxIntervals + 1);
    localparam logic [ValueWidth-1:0] VMax = '1;

    // Interval table: a row of cells reading their neighbors, and the head on a wrap-around rotation.
    logic [ValueWidth-1:0] r_lo [MaxIntervals];
    logic [ValueWidth-1:0] r_hi [MaxIntervals];
    logic [ValueWidth-1:0] n_lo [MaxIntervals];
    logic [ValueWidth-1:0] n_hi [MaxIntervals];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_idx;

    logic                  r_mode;
    logic [ValueWidth-1:0] r_v;
    t_status               r_status;
    t_status               n_status;

    // Per-entry compare flags.
    logic [MaxIntervals-1:0] r_gt, r_hit, r_left, r_right;
    logic [MaxIntervals-1:0] ge;

    // Capture the item on input transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_v    <= ValueWidth'(i_value);
        end
    end

    // Compare the value against every stored entry in parallel.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            for (int i = 0; i < MaxIntervals; i++) begin
                logic vld;
                vld        = CW'(i) < r_count;
                r_gt[i]    <= vld && (r_lo[i] > r_v);
                r_hit[i]   <= vld && (r_lo[i] <= r_v) && (r_hi[i] >= r_v);
                r_left[i]  <= vld && (r_v != '0) && (r_hi[i] == r_v - 1'b1);
                r_right[i] <= vld && (r_v != VMax) && (r_lo[i] == r_v + 1'b1);
            end
        end
    end

    // Entries at or past the insert position (empty slots count as past).
    always_comb begin
        for (int i = 0; i < MaxIntervals; i++) begin
            ge[i] = r_gt[i] || !(CW'(i) < r_count);
        end
    end

    // Decide the add outcome.
    always_comb begin
        if (|r_hit) begin
            n_status = ST_PRESENT;
        end else if ((|r_left) && (|r_right)) begin
            n_status = ST_MERGE;
        end else if ((|r_left) || (|r_right)) begin
            n_status = ST_EXTEND;
        end else if (r_count == CW'(MaxIntervals)) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_NEW;
        end
    end

    // Next table contents for an update or a listing rotation.
    always_comb begin
        n_count = r_count;
        for (int i = 0; i < MaxIntervals; i++) begin
            int up;
            int dn;
            up = (i < MaxIntervals - 1) ? i + 1 : i;
            dn = (i > 0) ? i - 1 : i;
            n_lo[i] = r_lo[i];
            n_hi[i] = r_hi[i];
            if (i_cmd.rotate) begin
                if (CW'(i + 1) < r_count) begin
                    n_lo[i] = r_lo[up];
                    n_hi[i] = r_hi[up];
                end else if (CW'(i + 1) == r_count) begin
                    n_lo[i] = r_lo[0];
                    n_hi[i] = r_hi[0];
                end
            end else if (i_cmd.upd) begin
                case (n_status)
                    ST_MERGE: begin
                        // Left entry absorbs the right one; the rest close the gap.
                        if (r_left[i]) begin
                            n_hi[i] = r_hi[up];
                        end else if (ge[i]) begin
                            n_lo[i] = r_lo[up];
                            n_hi[i] = r_hi[up];
                        end
                    end
                    ST_EXTEND: begin
                        if (r_right[i]) begin
                            n_lo[i] = r_v;
                        end else if (r_left[i]) begin
                            n_hi[i] = r_v;
                        end
                    end
                    ST_NEW: begin
                        // Open a slot at the insert position.
                        if (i > 0 && ge[dn]) begin
                            n_lo[i] = r_lo[dn];
                            n_hi[i] = r_hi[dn];
                        end else if (ge[i]) begin
                            n_lo[i] = r_v;
                            n_hi[i] = r_v;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (i_cmd.upd) begin
            if (n_status == ST_MERGE) begin
                n_count = r_count - 1'b1;
            end else if (n_status == ST_NEW) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // Table registers carry no reset.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MaxIntervals; i++) begin
            r_lo[i] <= n_lo[i];
            r_hi[i] <= n_hi[i];
        end
        if (i_cmd.upd) begin
            r_status <= n_status;
        end
    end

    // Count and listing position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.capture) begin
                r_idx <= '0;
            end else if (i_cmd.rotate) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.list_last  = (CW'(r_idx + 1'b1) == r_count);

    // Result payload; the head of the table is the interval being listed.
    always_comb begin
        logic [2:0]        st;
        logic [FieldW-1:0] lo;
        logic [FieldW-1:0] hi;
        logic              empty;
        st    = 3'(ST_PRESENT);
        lo    = '0;
        hi    = '0;
        empty = 1'b0;
        if (r_mode) begin
            empty = o_stat.count_zero;
            if (!empty) begin
                lo = FieldW'(r_lo[0]);
                hi = FieldW'(r_hi[0]);
            end
            o_last = empty || o_stat.list_last;
        end else begin
            st     = r_status;
            o_last = 1'b1;
        end
        o_kind = r_mode;
        o_data = {6'd0, CountOutW'(r_count), empty, hi, lo, st};
    end

endmodule

// ----- rtl/dit_checker.sv -----
`include "disjoint_interval_tracker_assert.svh"

module dit_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // The block takes no new item while a result is pending.
    `DIT_ASSERT_SAME(a_no_overlap, m_axis_tvalid, !s_axis_tready)

    // A stalled result holds.
    `DIT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // An add gives exactly one result.
    `DIT_ASSERT_SAME(a_add_single, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)

    // An empty listing is a single result with a zero count.
    `DIT_ASSERT_SAME(a_empty_list, m_axis_tvalid && m_axis_tdata[35], m_axis_tuser && m_axis_tlast && (m_axis_tdata[41:36] == 6'd0))

endmodule

bind disjoint_interval_tracker dit_checker u_dit_checker (.*);

// ----- tb/disjoint_interval_tracker_test.sv -----
module disjoint_interval_tracker_test;
    import dit_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TableDepth = DefMaxIntervals;
    localparam int IdleLimit  = 20000;

    typedef enum logic {MODE_ADD = 1'b0, MODE_LIST = 1'b1} t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] value;
    } t_request;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [15:0] lo;
        logic [15:0] hi;
        logic        empty;
        logic [5:0]  count;
        logic        last;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [FieldW-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    disjoint_interval_tracker dut (.*);

    always #6 i_clk = ~i_clk;

    // Shadow copy of the interval table.
    logic [15:0] lows[TableDepth];
    logic [15:0] highs[TableDepth];
    int          stored;

    t_request pending_requests[$];
    t_answer  expected_answers[$];
    int       mismatches;
    int       answers_seen;
    int       adds_sent;
    int       lists_sent;
    int       idle_cycles;
    bit       calm;
    bit       hold_off;

    function automatic t_status insert_value(logic [15:0] v);
        int pos;
        bit left_touch;
        bit right_touch;
        pos = stored;
        for (int i = 0; i < stored; i++) begin
            if (lows[i] > v) begin
                pos = i;
                break;
            end
        end
        if (pos > 0 && highs[pos-1] >= v) return ST_PRESENT;
        left_touch  = pos > 0 && v != 16'h0 && highs[pos-1] == v - 16'd1;
        right_touch = pos < stored && v != 16'hffff && lows[pos] == v + 16'd1;
        if (left_touch && right_touch) begin
            highs[pos-1] = highs[pos];
            for (int i = pos; i + 1 < stored; i++) begin
                lows[i]  = lows[i+1];
                highs[i] = highs[i+1];
            end
            stored--;
            return ST_MERGE;
        end
        if (right_touch) begin
            lows[pos] = v;
            return ST_EXTEND;
        end
        if (left_touch) begin
            highs[pos-1] = v;
            return ST_EXTEND;
        end
        if (stored >= TableDepth) return ST_FULL;
        for (int i = stored; i > pos; i--) begin
            lows[i]  = lows[i-1];
            highs[i] = highs[i-1];
        end
        lows[pos]  = v;
        highs[pos] = v;
        stored++;
        return ST_NEW;
    endfunction

    // Works out the answers to one accepted request.
    function automatic void predict_answers(t_request r);
        t_answer a;
        a = '0;
        if (r.mode == MODE_ADD) begin
            a.status = insert_value(r.value);
            a.count  = 6'(stored);
            a.last   = 1'b1;
            expected_answers.insert(expected_answers.size(), a);
            adds_sent++;
            return;
        end
        lists_sent++;
        a.kind  = 1'b1;
        a.count = 6'(stored);
        if (stored == 0) begin
            a.empty = 1'b1;
            a.last  = 1'b1;
            expected_answers.insert(expected_answers.size(), a);
            return;
        end
        for (int i = 0; i < stored; i++) begin
            a.lo   = lows[i];
            a.hi   = highs[i];
            a.last = (i == stored - 1);
            expected_answers.insert(expected_answers.size(), a);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d (answer %0d)",
                 what, got, want, answers_seen);
        mismatches++;
    endtask

    // Driver: offers queued requests, idling at random unless calm or holding off.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_answers(t_request'({s_axis_tuser, s_axis_tdata}));
                void'(pending_requests.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready) && pending_requests.size() > 0 &&
                    (calm || hold_off || $urandom_range(99) >= 14)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_requests[0].mode;
                s_axis_tdata  <= pending_requests[0].value;
            end else if (!s_axis_tvalid || s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each answer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_answer got;
                t_answer want;
                idle_cycles <= 0;
                got = {m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[18:3],
                       m_axis_tdata[34:19], m_axis_tdata[35], m_axis_tdata[41:36],
                       m_axis_tlast};
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected answer", 1, 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.lo != want.lo) report_mismatch("low", got.lo, want.lo);
                    if (got.hi != want.hi) report_mismatch("high", got.hi, want.hi);
                    if (got.empty != want.empty)
                        report_mismatch("empty", got.empty, want.empty);
                    if (got.count != want.count)
                        report_mismatch("count", got.count, want.count);
                    if (got.last != want.last) report_mismatch("last", got.last, want.last);
                    if (m_axis_tdata[47:42] != 0)
                        report_mismatch("fill", m_axis_tdata[47:42], 0);
                end
                answers_seen++;
            end else if (s_axis_tvalid && s_axis_tready) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 14);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (idle_cycles >= IdleLimit) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_request(t_mode m, logic [15:0] v);
        t_request r;
        r.mode  = m;
        r.value = v;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_axis_tvalid ||
               expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] base;
        stored = 0;
        mismatches = 0;
        answers_seen = 0;
        adds_sent = 0;
        lists_sent = 0;
        idle_cycles = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty listing, edges, extend on both sides, merge.
        queue_request(MODE_LIST, 16'h0);
        queue_request(MODE_ADD, 16'h0);
        queue_request(MODE_ADD, 16'h0);
        queue_request(MODE_ADD, 16'hffff);
        queue_request(MODE_ADD, 16'hfffe);
        queue_request(MODE_ADD, 16'h0002);
        queue_request(MODE_ADD, 16'h0001);
        queue_request(MODE_ADD, 16'h5555);
        queue_request(MODE_ADD, 16'haaaa);
        queue_request(MODE_ADD, 16'h5557);
        queue_request(MODE_ADD, 16'h5556);
        queue_request(MODE_ADD, 16'h5554);
        queue_request(MODE_ADD, 16'h5558);
        queue_request(MODE_LIST, 16'hffff);
        wait_drained();

        // Fill the table, hit the full case, then extend while full.
        for (int i = 0; i < 32; i++) queue_request(MODE_ADD, 16'(16'h1000 + 4 * i));
        queue_request(MODE_ADD, 16'h8000);
        queue_request(MODE_ADD, 16'h1002);
        queue_request(MODE_ADD, 16'h1001);
        queue_request(MODE_ADD, 16'h1003);
        queue_request(MODE_ADD, 16'h8000);
        queue_request(MODE_LIST, 16'h0);
        wait_drained();

        // Backpressure: receiver holds off while listings pile up.
        hold_off = 1'b1;
        queue_request(MODE_LIST, 16'h1234);
        queue_request(MODE_ADD, 16'h2000);
        queue_request(MODE_LIST, 16'h0);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
        wait_drained();

        // Random: clustered values so extends and merges are common.
        for (int n = 0; n < 115; n++) begin
            if (n == 60) calm = 1'b1;
            if (n == 100) calm = 1'b0;
            if ($urandom_range(9) == 0) begin
                queue_request(MODE_LIST, 16'($urandom));
            end else begin
                base = ($urandom_range(3) == 0) ? 16'($urandom)
                                                : 16'(16'h1000 + $urandom_range(200));
                queue_request(MODE_ADD, base);
            end
            if (n % 20 == 19) begin
                while (pending_requests.size() > 0) @(posedge i_clk);
            end
        end
        queue_request(MODE_LIST, 16'h0);
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d adds and %0d listings, %0d answers checked.",
                 adds_sent, lists_sent, answers_seen);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
